// File: src/dep_pkg.sv
// Shared types and constants for the depth edge potential pipeline.
// No dependencies; imported by every other file in src.
package dep_pkg;

  localparam int COORD_W    = 16;
  localparam int NORM_W     = 16;
  localparam int DIFF_W     = 17;
  localparam int PROD_W     = 33;
  localparam int SQR_W      = 32;
  localparam int DOT_W      = 34;
  localparam int DN_W       = 33;
  localparam int SQ_W       = 34;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = SQ_W + FRAC_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int PN_W       = DN_W + CFG_W;
  localparam int PD_W       = ROOT_W + CFG_W;
  localparam int BIG_W      = PN_W + 1;
  localparam int ARG_SHIFT  = 22;
  localparam int ARG_W      = BIG_W - ARG_SHIFT;
  localparam int K_W        = 4;
  localparam int TERM_W     = 33;
  localparam int SUM_W      = 36;
  localparam int POT_W      = 16;
  localparam int TAYLOR_STEPS = 13;
  localparam int POW_STEPS    = 11;

  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_NORMAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_DIST   = 1'b1;

  localparam logic [CFG_W-1:0] INV_SIGMA_NORMAL_RST = 24'd1677722;
  localparam logic [CFG_W-1:0] INV_SIGMA_DIST_RST   = 24'd167772;

  // exponent argument limit: 12.0 in Q.16
  localparam logic [ARG_W-1:0]  ARG_LIMIT = ARG_W'(12 << 16);
  localparam logic [TERM_W-1:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0]       ROUND_Q32 = 32'h8000_0000;
  // exp(-1) through the same truncated series, Q.32
  localparam logic [31:0]       EXP_M1_Q32 = 32'd1580030169;
  localparam logic [POT_W-1:0]  POT_MAX = 16'hFFFF;

  // floor(2^32 / n) for the series divisors; entry 0 (n = 1) unused
  localparam logic [31:0] RECIP_Q32 [TAYLOR_STEPS] = '{
    32'd0,         32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459, 32'd715827882,  32'd613566756,  32'd536870912,
    32'd477218588, 32'd429496729,  32'd390451572,  32'd357913941,
    32'd330382099
  };

  typedef struct packed {
    logic           zero;
    logic [K_W-1:0] k;
  } exp_side_t;

  typedef struct packed {
    logic       en;
    logic [1:0] cnt;
  } ofifo_stat_t;

endpackage

// File: src/dep_if.sv
// Valid/ready channel interfaces for edge words in and potential words out.
// Depends on dep_pkg.
interface dep_in_if import dep_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      first_valid;
  logic                      second_valid;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic signed [COORD_W-1:0] second_z;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;
  logic signed [NORM_W-1:0]  normal_z;

  modport source (
    output valid, first_valid, second_valid, first_x, first_y, first_z,
           second_x, second_y, second_z, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, first_valid, second_valid, first_x, first_y, first_z,
           second_x, second_y, second_z, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

interface dep_out_if import dep_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POT_W-1:0] potential;

  modport source (output valid, potential, input ready);
  modport sink (input valid, potential, output ready);
endinterface

// File: src/dep_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on dep_pkg.
module dep_sqrt import dep_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = ROOT_W;

  logic              v_r    [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [ROOT_W-1:0] root_r [STEPS];
  logic [RAD_W-1:0]  rad_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  logic              v_in    [STEPS];
  logic [REM_W-1:0]  rem_in  [STEPS];
  logic [ROOT_W-1:0] root_in [STEPS];
  logic [RAD_W-1:0]  rad_sin [STEPS];
  logic [SIDE_W-1:0] side_sin[STEPS];

  logic [REM_W-1:0]  rem_nxt  [STEPS];
  logic [ROOT_W-1:0] root_nxt [STEPS];

  always_comb begin
    v_in[0]     = valid_in;
    rem_in[0]   = '0;
    root_in[0]  = '0;
    rad_sin[0]  = rad_in;
    side_sin[0] = side_in;
    for (int s = 1; s < STEPS; s++) begin
      v_in[s]     = v_r[s-1];
      rem_in[s]   = rem_r[s-1];
      root_in[s]  = root_r[s-1];
      rad_sin[s]  = rad_r[s-1];
      side_sin[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int s = 0; s < STEPS; s++) begin
      cur   = {rem_in[s][REM_W-3:0], rad_sin[s][RAD_W-1 -: 2]};
      trial = REM_W'({root_in[s], 2'b01});
      ge    = (cur >= trial);
      rem_nxt[s]  = ge ? (cur - trial) : cur;
      root_nxt[s] = {root_in[s][ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STEPS; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        rad_r[s]  <= {rad_sin[s][RAD_W-3:0], 2'b00};
        side_r[s] <= side_sin[s];
      end
    end
  end

  assign valid_out = v_r[STEPS-1];
  assign root_out  = root_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

// File: src/dep_taylor.sv
// exp(-f) for a Q.16 fraction by a 13-term series in Q.32, three stages per term:
// multiply by f, multiply by reciprocal of n, exact correction and accumulate.
// Depends on dep_pkg.
module dep_taylor import dep_pkg::*; #(
  parameter int SIDE_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [FRAC_W-1:0] f_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [TERM_W-1:0] e_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = TAYLOR_STEPS;
  localparam int MF_W  = TERM_W + FRAC_W;
  localparam int MR_W  = TERM_W + 32;
  localparam int CR_W  = TERM_W + 4;

  // stage A: term * f
  logic                    va_r   [STEPS];
  logic [TERM_W-1:0]       xa_r   [STEPS];
  logic signed [SUM_W-1:0] suma_r [STEPS];
  logic [FRAC_W-1:0]       fa_r   [STEPS];
  logic [SIDE_W-1:0]       sda_r  [STEPS];
  // stage B: estimate quotient
  logic                    vb_r   [STEPS];
  logic [TERM_W-1:0]       xb_r   [STEPS];
  logic [TERM_W-1:0]       q0b_r  [STEPS];
  logic signed [SUM_W-1:0] sumb_r [STEPS];
  logic [FRAC_W-1:0]       fb_r   [STEPS];
  logic [SIDE_W-1:0]       sdb_r  [STEPS];
  // stage C: corrected term, running sum
  logic                    vc_r   [STEPS];
  logic [TERM_W-1:0]       termc_r[STEPS];
  logic signed [SUM_W-1:0] sumc_r [STEPS];
  logic [FRAC_W-1:0]       fc_r   [STEPS];
  logic [SIDE_W-1:0]       sdc_r  [STEPS];

  logic                    vi    [STEPS];
  logic [TERM_W-1:0]       ti    [STEPS];
  logic signed [SUM_W-1:0] si    [STEPS];
  logic [FRAC_W-1:0]       fi    [STEPS];
  logic [SIDE_W-1:0]       sdi   [STEPS];

  logic [TERM_W-1:0]       xa_nxt   [STEPS];
  logic [TERM_W-1:0]       q0_nxt   [STEPS];
  logic [TERM_W-1:0]       term_nxt [STEPS];
  logic signed [SUM_W-1:0] sum_nxt  [STEPS];

  logic                    vo_r;
  logic [TERM_W-1:0]       eo_r;
  logic [SIDE_W-1:0]       sdo_r;
  logic [TERM_W-1:0]       e_clamp;

  always_comb begin
    vi[0]  = valid_in;
    ti[0]  = ONE_Q32;
    si[0]  = SUM_W'(ONE_Q32);
    fi[0]  = f_in;
    sdi[0] = side_in;
    for (int s = 1; s < STEPS; s++) begin
      vi[s]  = vc_r[s-1];
      ti[s]  = termc_r[s-1];
      si[s]  = sumc_r[s-1];
      fi[s]  = fc_r[s-1];
      sdi[s] = sdc_r[s-1];
    end
  end

  always_comb begin
    logic [MF_W-1:0]   prod;
    logic [MR_W-1:0]   qm;
    logic [CR_W-1:0]   pn;
    logic [CR_W-1:0]   r0;
    logic [CR_W-1:0]   r1;
    logic [CR_W-1:0]   nv;
    logic              c1;
    logic              c2;
    logic [TERM_W-1:0] q;
    for (int s = 0; s < STEPS; s++) begin
      prod      = MF_W'(ti[s]) * MF_W'(fi[s]);
      xa_nxt[s] = prod[MF_W-1:FRAC_W];

      qm        = MR_W'(xa_r[s]) * MR_W'(RECIP_Q32[s]);
      q0_nxt[s] = (s == 0) ? xa_r[s] : qm[MR_W-1:32];

      // estimate is at most two short of floor(x / n)
      nv = CR_W'(s + 1);
      pn = CR_W'(q0b_r[s]) * nv;
      r0 = CR_W'(xb_r[s]) - pn;
      c1 = (r0 >= nv);
      r1 = c1 ? (r0 - nv) : r0;
      c2 = (r1 >= nv);
      q  = (s == 0) ? xb_r[s] : (q0b_r[s] + TERM_W'(c1) + TERM_W'(c2));
      term_nxt[s] = q;
      if ((s % 2) == 0) begin
        sum_nxt[s] = sumb_r[s] - $signed(SUM_W'(q));
      end else begin
        sum_nxt[s] = sumb_r[s] + $signed(SUM_W'(q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) begin
        va_r[s] <= 1'b0;
        vb_r[s] <= 1'b0;
        vc_r[s] <= 1'b0;
      end
      vo_r <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        va_r[s] <= vi[s];
        vb_r[s] <= va_r[s];
        vc_r[s] <= vb_r[s];
      end
      vo_r <= vc_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        xa_r[s]    <= xa_nxt[s];
        suma_r[s]  <= si[s];
        fa_r[s]    <= fi[s];
        sda_r[s]   <= sdi[s];
        xb_r[s]    <= xa_r[s];
        q0b_r[s]   <= q0_nxt[s];
        sumb_r[s]  <= suma_r[s];
        fb_r[s]    <= fa_r[s];
        sdb_r[s]   <= sda_r[s];
        termc_r[s] <= term_nxt[s];
        sumc_r[s]  <= sum_nxt[s];
        fc_r[s]    <= fb_r[s];
        sdc_r[s]   <= sdb_r[s];
      end
      eo_r  <= e_clamp;
      sdo_r <= sdc_r[STEPS-1];
    end
  end

  always_comb begin
    if (sumc_r[STEPS-1] < 0) begin
      e_clamp = '0;
    end else if (sumc_r[STEPS-1] > $signed(SUM_W'(ONE_Q32))) begin
      e_clamp = ONE_Q32;
    end else begin
      e_clamp = sumc_r[STEPS-1][TERM_W-1:0];
    end
  end

  assign valid_out = vo_r;
  assign e_out     = eo_r;
  assign side_out  = sdo_r;

endmodule

// File: src/dep_pow.sv
// Applies exp(-1) once per integer unit of the argument (one stage each),
// then scales to Q0.16 with rounding and saturation, or gives zero when flagged.
// Depends on dep_pkg.
module dep_pow import dep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [TERM_W-1:0] e_in,
  input  exp_side_t         side_in,
  output logic              valid_out,
  output logic [POT_W-1:0]  pot_out
);

  localparam int STEPS = POW_STEPS;
  localparam int MP_W  = TERM_W + 32;
  localparam int SC_W  = TERM_W + POT_W;

  logic              v_r  [STEPS];
  logic [TERM_W-1:0] e_r  [STEPS];
  exp_side_t         sd_r [STEPS];

  logic              vi  [STEPS];
  logic [TERM_W-1:0] ei  [STEPS];
  exp_side_t         sdi [STEPS];
  logic [TERM_W-1:0] e_nxt [STEPS];

  logic              vo_r;
  logic [POT_W-1:0]  pot_r;
  logic [POT_W-1:0]  pot_nxt;

  always_comb begin
    vi[0]  = valid_in;
    ei[0]  = e_in;
    sdi[0] = side_in;
    for (int s = 1; s < STEPS; s++) begin
      vi[s]  = v_r[s-1];
      ei[s]  = e_r[s-1];
      sdi[s] = sd_r[s-1];
    end
  end

  always_comb begin
    logic [MP_W-1:0] m;
    for (int s = 0; s < STEPS; s++) begin
      m = MP_W'(ei[s]) * MP_W'(EXP_M1_Q32) + MP_W'(ROUND_Q32);
      e_nxt[s] = (sdi[s].k > K_W'(s)) ? m[MP_W-1:32] : ei[s];
    end
  end

  // e * 65535 as a shift and subtract
  always_comb begin
    logic [SC_W-1:0]  t;
    logic [SC_W-33:0] p;
    t = SC_W'({e_r[STEPS-1], {POT_W{1'b0}}}) - SC_W'(e_r[STEPS-1]) + SC_W'(ROUND_Q32);
    p = t[SC_W-1:32];
    if (sd_r[STEPS-1].zero) begin
      pot_nxt = '0;
    end else if (p > (SC_W-32)'(POT_MAX)) begin
      pot_nxt = POT_MAX;
    end else begin
      pot_nxt = p[POT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) begin
        v_r[s] <= 1'b0;
      end
      vo_r <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        v_r[s] <= vi[s];
      end
      vo_r <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        e_r[s]  <= e_nxt[s];
        sd_r[s] <= sdi[s];
      end
      pot_r <= pot_nxt;
    end
  end

  assign valid_out = vo_r;
  assign pot_out   = pot_r;

endmodule

// File: src/dep_ofifo.sv
// Two-word output buffer; lets the pipeline keep moving while one result waits.
// Depends on dep_pkg.
module dep_ofifo import dep_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [POT_W-1:0] push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POT_W-1:0] out_data,
  output ofifo_stat_t      stat
);

  localparam logic [1:0] FULL = 2'd2;

  logic [POT_W-1:0] data_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             en;
  logic             push;
  logic             pop;

  assign en   = (cnt_r != FULL) || out_ready;
  assign push = en && push_valid;
  assign pop  = (cnt_r != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = data_r[rd_ptr_r];
  assign stat.en   = en;
  assign stat.cnt  = cnt_r;

endmodule

// File: src/depth_edge_potential_unit.sv
// Depth edge potential: exp(-|d.n|*inv_sigma_normal - |d|*inv_sigma_dist), Q0.16.
// One word per cycle sustained unless the output applies back-pressure.
// Length set by the 25-stage square root, 40-stage series unit and 11 exp(-1) stages.
// 2-word output buffer absorbs back-pressure; all stages stall while it is full and unread.
// Synchronous active-low reset clears valid bits and buffer state, presets both sigmas.
module depth_edge_potential_unit import dep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dep_in_if.sink               in_chan,
  dep_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SQ_SIDE_W = DN_W + 1;
  localparam int EX_SIDE_W = $bits(exp_side_t);

  logic [CFG_W-1:0] inv_sigma_normal_r;
  logic [CFG_W-1:0] inv_sigma_dist_r;

  ofifo_stat_t stat;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_sigma_normal_r <= INV_SIGMA_NORMAL_RST;
      inv_sigma_dist_r   <= INV_SIGMA_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_SIGMA_NORMAL: inv_sigma_normal_r <= cfg_wdata;
        REG_INV_SIGMA_DIST:   inv_sigma_dist_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en            = stat.en;
  assign in_chan.ready = en;

  // S0: input word
  logic                      v0_r, fv0_r, sv0_r;
  logic signed [COORD_W-1:0] ax0_r, ay0_r, az0_r, bx0_r, by0_r, bz0_r;
  logic signed [NORM_W-1:0]  nx0_r, ny0_r, nz0_r;
  // S1: differences
  logic                      v1_r, zero1_r;
  logic signed [DIFF_W-1:0]  dx1_r, dy1_r, dz1_r;
  logic signed [NORM_W-1:0]  nx1_r, ny1_r, nz1_r;
  // S2: products
  logic                      v2_r, zero2_r;
  logic signed [PROD_W-1:0]  px2_r, py2_r, pz2_r;
  logic [SQR_W-1:0]          sx2_r, sy2_r, sz2_r;
  // S3: sums
  logic                      v3_r, zero3_r;
  logic [DN_W-1:0]           dn3_r;
  logic [SQ_W-1:0]           sq3_r;

  logic signed [2*DIFF_W-1:0] sqx, sqy, sqz;
  logic signed [DOT_W-1:0]    dot;

  assign sqx = (2*DIFF_W)'(dx1_r) * (2*DIFF_W)'(dx1_r);
  assign sqy = (2*DIFF_W)'(dy1_r) * (2*DIFF_W)'(dy1_r);
  assign sqz = (2*DIFF_W)'(dz1_r) * (2*DIFF_W)'(dz1_r);
  assign dot = DOT_W'(px2_r) + DOT_W'(py2_r) + DOT_W'(pz2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fv0_r <= in_chan.first_valid;
      sv0_r <= in_chan.second_valid;
      ax0_r <= in_chan.first_x;
      ay0_r <= in_chan.first_y;
      az0_r <= in_chan.first_z;
      bx0_r <= in_chan.second_x;
      by0_r <= in_chan.second_y;
      bz0_r <= in_chan.second_z;
      nx0_r <= in_chan.normal_x;
      ny0_r <= in_chan.normal_y;
      nz0_r <= in_chan.normal_z;

      zero1_r <= !(fv0_r && sv0_r);
      dx1_r   <= DIFF_W'(bx0_r) - DIFF_W'(ax0_r);
      dy1_r   <= DIFF_W'(by0_r) - DIFF_W'(ay0_r);
      dz1_r   <= DIFF_W'(bz0_r) - DIFF_W'(az0_r);
      nx1_r   <= nx0_r;
      ny1_r   <= ny0_r;
      nz1_r   <= nz0_r;

      zero2_r <= zero1_r;
      px2_r   <= PROD_W'(dx1_r) * PROD_W'(nx1_r);
      py2_r   <= PROD_W'(dy1_r) * PROD_W'(ny1_r);
      pz2_r   <= PROD_W'(dz1_r) * PROD_W'(nz1_r);
      sx2_r   <= sqx[SQR_W-1:0];
      sy2_r   <= sqy[SQR_W-1:0];
      sz2_r   <= sqz[SQR_W-1:0];

      zero3_r <= zero2_r;
      dn3_r   <= (dot < 0) ? DN_W'(-dot) : DN_W'(dot);
      sq3_r   <= SQ_W'(sx2_r) + SQ_W'(sy2_r) + SQ_W'(sz2_r);
    end
  end

  // square root of |d|^2 in Q.16, dn and the invalid flag ride alongside
  logic                 v4;
  logic [ROOT_W-1:0]    de4;
  logic [SQ_SIDE_W-1:0] sd4;

  dep_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v3_r),
    .rad_in    ({sq3_r, {FRAC_W{1'b0}}}),
    .side_in   ({zero3_r, dn3_r}),
    .valid_out (v4),
    .root_out  (de4),
    .side_out  (sd4)
  );

  // S5: scale by sigmas; S6: argument and range check
  logic             v5_r, zero5_r;
  logic [PN_W-1:0]  pn5_r;
  logic [PD_W-1:0]  pd5_r;
  logic             v6_r;
  exp_side_t        sd6_r;
  logic [FRAC_W-1:0] f6_r;

  logic [BIG_W-1:0] big;
  logic [ARG_W-1:0] arg;

  assign big = BIG_W'(pn5_r) + BIG_W'({pd5_r, 6'b0});
  assign arg = big[BIG_W-1:ARG_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero5_r    <= sd4[SQ_SIDE_W-1];
      pn5_r      <= PN_W'(sd4[DN_W-1:0]) * PN_W'(inv_sigma_normal_r);
      pd5_r      <= PD_W'(de4) * PD_W'(inv_sigma_dist_r);
      sd6_r.zero <= zero5_r || (arg >= ARG_LIMIT);
      sd6_r.k    <= arg[FRAC_W+K_W-1:FRAC_W];
      f6_r       <= arg[FRAC_W-1:0];
    end
  end

  logic                 v7;
  logic [TERM_W-1:0]    e7;
  logic [EX_SIDE_W-1:0] sd7;

  dep_taylor #(.SIDE_W(EX_SIDE_W)) u_taylor (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v6_r),
    .f_in      (f6_r),
    .side_in   (sd6_r),
    .valid_out (v7),
    .e_out     (e7),
    .side_out  (sd7)
  );

  logic             v_last;
  logic [POT_W-1:0] pot_last;

  dep_pow u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v7),
    .e_in      (e7),
    .side_in   (exp_side_t'(sd7)),
    .valid_out (v_last),
    .pot_out   (pot_last)
  );

  dep_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (v_last),
    .push_data  (pot_last),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_data   (out_chan.potential),
    .stat       (stat)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cnt != 2'd3)
    else $error("output buffer count out of range");

  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result waiting");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.en && v_last && !(out_chan.valid && out_chan.ready))
      |=> stat.cnt == 2'($past(stat.cnt) + 2'd1))
    else $error("pushed word not counted");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for depth_edge_potential_unit: directed and random edge words.
// Depends on dep_pkg, the dep_in_if / dep_out_if interfaces and depth_edge_potential_unit in src.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dep_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    bit                  first_valid;
    bit                  second_valid;
    logic signed [15:0]  fx, fy, fz;
    logic signed [15:0]  sx, sy, sz;
    logic signed [15:0]  nx, ny, nz;
  } edge_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INV_SIGMA_NORMAL;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dep_in_if  in_if();
  dep_out_if out_if();

  depth_edge_potential_unit uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if.sink), .out_chan(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint unsigned sigma_normal = INV_SIGMA_NORMAL_RST;
  longint unsigned sigma_dist   = INV_SIGMA_DIST_RST;
  logic [POT_W-1:0] expected_potentials[$];
  int  mismatches = 0;
  int  words_checked = 0;
  int  words_sent = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  out_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp(-f), f in Q.16 up to 1.0, truncated series, Q.32 out
  function automatic longint unsigned exp_neg_q32(longint unsigned f);
    longint unsigned term;
    longint sum;
    term = 64'd1 << 32;
    sum = 64'sd1 <<< 32;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * f) >> 16) / n;
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 32)) sum = 64'sd1 <<< 32;
    return longint'(sum);
  endfunction

  function automatic logic [POT_W-1:0] predict_potential(edge_pair_t p);
    longint dx, dy, dz, dot;
    longint unsigned dn, sq, de, arg_big, a, e, e1, pot;
    if (!p.first_valid || !p.second_valid) return '0;
    dx = longint'(p.sx) - longint'(p.fx);
    dy = longint'(p.sy) - longint'(p.fy);
    dz = longint'(p.sz) - longint'(p.fz);
    dot = dx * longint'(p.nx) + dy * longint'(p.ny) + dz * longint'(p.nz);
    dn = (dot < 0) ? -dot : dot;
    sq = dx * dx + dy * dy + dz * dz;
    de = int_sqrt(sq << 16);
    arg_big = dn * sigma_normal + ((de * sigma_dist) << 6);
    a = arg_big >> 22;
    if (a >= (64'd12 << 16)) return '0;
    e = exp_neg_q32(a & 64'hFFFF);
    e1 = exp_neg_q32(64'd65536);
    for (longint unsigned i = 0; i < (a >> 16); i++)
      e = (e * e1 + (64'd1 << 31)) >> 32;
    pot = (e * 64'd65535 + (64'd1 << 31)) >> 32;
    if (pot > 64'd65535) pot = 64'd65535;
    return pot[15:0];
  endfunction

  task automatic send_pair(edge_pair_t p);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.first_valid <= p.first_valid;
    in_if.second_valid <= p.second_valid;
    in_if.first_x <= p.fx;
    in_if.first_y <= p.fy;
    in_if.first_z <= p.fz;
    in_if.second_x <= p.sx;
    in_if.second_y <= p.sy;
    in_if.second_z <= p.sz;
    in_if.normal_x <= p.nx;
    in_if.normal_y <= p.ny;
    in_if.normal_z <= p.nz;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_potentials.push_back(predict_potential(p));
    words_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_potentials.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_sigmas(logic [CFG_W-1:0] s_norm, logic [CFG_W-1:0] s_dist);
    cfg_we <= 1'b1;
    cfg_index <= REG_INV_SIGMA_NORMAL;
    cfg_wdata <= s_norm;
    @(posedge clk);
    cfg_index <= REG_INV_SIGMA_DIST;
    cfg_wdata <= s_dist;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sigma_normal = s_norm;
    sigma_dist = s_dist;
  endtask

  function automatic edge_pair_t make_pair(bit fv, bit sv, int fx, int fy, int fz,
                                           int sx, int sy, int sz, int nx, int ny, int nz);
    edge_pair_t p;
    p.first_valid = fv; p.second_valid = sv;
    p.fx = 16'(fx); p.fy = 16'(fy); p.fz = 16'(fz);
    p.sx = 16'(sx); p.sy = 16'(sy); p.sz = 16'(sz);
    p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz);
    return p;
  endfunction

  function automatic logic signed [15:0] near(logic signed [15:0] base, int span);
    return base + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  function automatic edge_pair_t random_pair();
    edge_pair_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p.first_valid = 1'b1;
    p.second_valid = 1'b1;
    {p.fx, p.fy, p.fz} = {16'($urandom), 16'($urandom), 16'($urandom)};
    if (kind < 70) begin
      p.sx = near(p.fx, 96); p.sy = near(p.fy, 96); p.sz = near(p.fz, 96);
    end else begin
      {p.sx, p.sy, p.sz} = {16'($urandom), 16'($urandom), 16'($urandom)};
    end
    if (kind % 10 == 3) begin
      {p.nx, p.ny, p.nz} = {16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      p.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
      p.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
      p.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    if (kind >= 90) {p.first_valid, p.second_valid} = 2'($urandom_range(0, 2));
    return p;
  endfunction

  task automatic test_invalid_pixels();
    send_pair(make_pair(0, 1, 10, 20, 30, 11, 20, 30, 0, 0, 16384));
    send_pair(make_pair(1, 0, 10, 20, 30, 10, 20, 30, 0, 0, 16384));
    send_pair(make_pair(0, 0, -5, 7, 900, -5, 7, 900, 16384, 0, 0));
  endtask

  task automatic test_extremes();
    // identical points: exp(0) saturates
    send_pair(make_pair(1, 1, 123, -456, 789, 123, -456, 789, 0, 16384, 0));
    send_pair(make_pair(1, 1, 0, 0, 1000, 1, 0, 1000, 0, 0, 16384));
    send_pair(make_pair(1, 1, 0, 0, 1000, 0, 0, 1010, 0, 0, 16384));
    send_pair(make_pair(1, 1, 0, 0, 1000, 0, 0, 1100, 0, 0, -16384));
    send_pair(make_pair(1, 1, -32768, -32768, -32768, 32767, 32767, 32767,
                        16384, 16384, 16384));
    send_pair(make_pair(1, 1, 32767, 32767, 32767, -32768, -32768, -32768,
                        -16384, -16384, -16384));
    // normal components beyond one
    send_pair(make_pair(1, 1, 0, 0, 0, 3, -2, 1, -32768, 32767, -32768));
    send_pair(make_pair(1, 1, -1, -1, -1, 0, 0, 0, 32767, 32767, 32767));
    send_pair(make_pair(1, 1, 500, 500, 500, 540, 470, 510, 0, 0, 0));
  endtask

  task automatic test_config_extremes();
    drain();
    write_sigmas('0, '0);
    test_extremes();
    drain();
    write_sigmas(24'hFFFFFF, 24'hFFFFFF);
    test_extremes();
    drain();
    write_sigmas(24'hFFFFFF, '0);
    send_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, 16384, 0, 0));
    send_pair(make_pair(1, 1, 0, 0, 0, 1, 0, 0, 0, 16384, 0));
    drain();
    write_sigmas('0, 24'd4096);
    send_pair(make_pair(1, 1, 0, 0, 0, 2, 3, 4, 16384, 0, 0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) idle_on = ~idle_on;
      send_pair(random_pair());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_sigmas();
    logic [CFG_W-1:0] s_norm, s_dist;
    for (int round = 0; round < 5; round++) begin
      drain();
      s_norm = (round % 2 == 0) ? 24'($urandom_range(1 << 14, 1 << 22))
                                : 24'($urandom);
      s_dist = (round % 2 == 0) ? 24'($urandom_range(1 << 12, 1 << 20))
                                : 24'($urandom);
      write_sigmas(s_norm, s_dist);
      test_random(250);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_if.ready <= 1'b1;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_if.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      out_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    logic [POT_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_potentials.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: potential=%0d", out_if.potential);
        mismatches++;
      end else begin
        want = expected_potentials.pop_front();
        words_checked++;
        if (out_if.potential !== want) begin
          if (mismatches < 10)
            $display("potential mismatch: expected %0d, got %0d", want, out_if.potential);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.first_valid = 1'b0;
    in_if.second_valid = 1'b0;
    {in_if.first_x, in_if.first_y, in_if.first_z} = '0;
    {in_if.second_x, in_if.second_y, in_if.second_z} = '0;
    {in_if.normal_x, in_if.normal_y, in_if.normal_z} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_invalid_pixels();
    test_extremes();
    test_random(300);
    test_config_extremes();
    test_random_sigmas();
    drain();
    write_sigmas(INV_SIGMA_NORMAL_RST, INV_SIGMA_DIST_RST);
    test_random(100);
    drain();
    if (expected_potentials.size() != 0) mismatches++;
    $display("covered %0d edge words, %0d potentials checked, %0d mismatches",
             words_sent, words_checked, mismatches);
    $display("sigma settings: reset, zero, full scale and five random pairs");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/dep_pkg.sv
src/dep_if.sv
src/dep_sqrt.sv
src/dep_taylor.sv
src/dep_pow.sv
src/dep_ofifo.sv
src/depth_edge_potential_unit.sv
bench/tb_top.sv
